// ----- sv/xesc_pkg.sv -----
// ----------------------------------------------------------------------------
// xesc_pkg
// Shared types, constants and helpers for the XML text escape encoder.
// ----------------------------------------------------------------------------
package xesc_pkg;

   localparam int CpW      = 21;
   localparam int ByteW    = 7;
   localparam int MaxBytes = 10;
   localparam int LenW     = $clog2(MaxBytes + 1);
   localparam int IdxW     = $clog2(MaxBytes);
   localparam int NibCnt   = 6;

   // ASCII characters used by the escape sequences
   localparam logic [ByteW-1:0] ChAmp   = 7'h26;
   localparam logic [ByteW-1:0] ChHash  = 7'h23;
   localparam logic [ByteW-1:0] ChX     = 7'h78;
   localparam logic [ByteW-1:0] ChSemi  = 7'h3b;
   localparam logic [ByteW-1:0] ChLt    = 7'h3c;
   localparam logic [ByteW-1:0] ChApos  = 7'h27;
   localparam logic [ByteW-1:0] ChQuot  = 7'h22;
   localparam logic [ByteW-1:0] ChDel   = 7'h7f;
   localparam logic [ByteW-1:0] ChLowA  = 7'h61;
   localparam logic [ByteW-1:0] ChLowL  = 7'h6c;
   localparam logic [ByteW-1:0] ChLowM  = 7'h6d;
   localparam logic [ByteW-1:0] ChLowO  = 7'h6f;
   localparam logic [ByteW-1:0] ChLowP  = 7'h70;
   localparam logic [ByteW-1:0] ChLowQ  = 7'h71;
   localparam logic [ByteW-1:0] ChLowS  = 7'h73;
   localparam logic [ByteW-1:0] ChLowT  = 7'h74;
   localparam logic [ByteW-1:0] ChLowU  = 7'h75;
   localparam logic [ByteW-1:0] ChZero  = 7'h30;

   typedef enum logic [2:0] {
      KIND_PASS,
      KIND_LT,
      KIND_APOS,
      KIND_QUOT,
      KIND_AMP,
      KIND_DEC,
      KIND_HEX
   } kind_type;

   // One fully expanded escape run, ready to be serialized.
   typedef struct packed {
      logic [MaxBytes-1:0][ByteW-1:0] bytes;
      logic [LenW-1:0]                len;
   } item_type;

   function automatic logic [ByteW-1:0] hex_char(input logic [3:0] d);
      logic [ByteW-1:0] ch;
      if (d < 4'd10) begin
         ch = ChZero + {3'b000, d};
      end else begin
         ch = ChLowA + {3'b000, d} - 7'd10;
      end
      return ch;
   endfunction

endpackage

// ----- sv/xesc_front.sv -----
// ----------------------------------------------------------------------------
// xesc_front
// Classifies one code point and expands it into its escaped byte run.
// ----------------------------------------------------------------------------
module xesc_front (
   input  logic [xesc_pkg::CpW-1:0] code_point,
   input  logic                     escape_ctl,
   output xesc_pkg::item_type       item
);
   import xesc_pkg::*;

   logic [ByteW-1:0]         ch;
   logic                     is_ascii;
   logic                     is_ctrl;
   kind_type                 kind;
   logic [NibCnt-1:0][3:0]   nib;
   logic [2:0]               nd;
   logic [1:0]               pl;
   logic                     dec_h;
   logic [ByteW-1:0]         dec_r;
   logic [14:0]              dec_prod;
   logic [3:0]               dec_t;
   logic [ByteW-1:0]         dec_t10;
   logic [3:0]               dec_u;
   logic [LenW-1:0]          k_v;
   logic [2:0]               d_idx;

   assign ch       = code_point[ByteW-1:0];
   assign is_ascii = (code_point[CpW-1:ByteW] == '0);
   assign is_ctrl  = ((ch < 7'h20) || (ch == ChDel)) && !((ch >= 7'h09) && (ch <= 7'h0d));

   always_comb begin
      if (!is_ascii) begin
         kind = KIND_HEX;
      end else if (ch == ChLt) begin
         kind = KIND_LT;
      end else if (ch == ChApos) begin
         kind = KIND_APOS;
      end else if (ch == ChQuot) begin
         kind = KIND_QUOT;
      end else if (ch == ChAmp) begin
         kind = KIND_AMP;
      end else if (is_ctrl && escape_ctl) begin
         kind = KIND_DEC;
      end else begin
         kind = KIND_PASS;
      end
   end

   // decimal digits of a 7-bit value; tens via reciprocal 205/2048
   assign dec_h    = (ch >= 7'd100);
   assign dec_r    = dec_h ? (ch - 7'd100) : ch;
   assign dec_prod = 15'(dec_r) * 15'd205;
   assign dec_t    = dec_prod[14:11];
   assign dec_t10  = 7'({3'b000, dec_t} * 7'd10);
   assign dec_u    = 4'(dec_r - dec_t10);

   always_comb begin
      nib = '0;
      nd  = 3'd1;
      pl  = 2'd2;
      if (kind == KIND_HEX) begin
         pl = 2'd3;
         for (int j = 0; j < NibCnt - 1; j++) begin
            nib[j] = code_point[4*j +: 4];
         end
         nib[NibCnt-1] = {3'b000, code_point[CpW-1]};
         for (int j = 0; j < NibCnt; j++) begin
            if (nib[j] != 4'd0) begin
               nd = 3'(j + 1);
            end
         end
      end else begin
         nib[0] = dec_u;
         nib[1] = dec_t;
         nib[2] = {3'b000, dec_h};
         if (dec_h) begin
            nd = 3'd3;
         end else if (dec_t != 4'd0) begin
            nd = 3'd2;
         end
      end
   end

   always_comb begin
      item  = '0;
      k_v   = '0;
      d_idx = '0;
      case (kind)
         KIND_PASS: begin
            item.bytes[0] = ch;
            item.len      = LenW'(1);
         end
         KIND_LT: begin
            item.bytes[0] = ChAmp;
            item.bytes[1] = ChLowL;
            item.bytes[2] = ChLowT;
            item.bytes[3] = ChSemi;
            item.len      = LenW'(4);
         end
         KIND_APOS: begin
            item.bytes[0] = ChAmp;
            item.bytes[1] = ChLowA;
            item.bytes[2] = ChLowP;
            item.bytes[3] = ChLowO;
            item.bytes[4] = ChLowS;
            item.bytes[5] = ChSemi;
            item.len      = LenW'(6);
         end
         KIND_QUOT: begin
            item.bytes[0] = ChAmp;
            item.bytes[1] = ChLowQ;
            item.bytes[2] = ChLowU;
            item.bytes[3] = ChLowO;
            item.bytes[4] = ChLowT;
            item.bytes[5] = ChSemi;
            item.len      = LenW'(6);
         end
         KIND_AMP: begin
            item.bytes[0] = ChAmp;
            item.bytes[1] = ChLowA;
            item.bytes[2] = ChLowM;
            item.bytes[3] = ChLowP;
            item.bytes[4] = ChSemi;
            item.len      = LenW'(5);
         end
         KIND_DEC, KIND_HEX: begin
            // prefix, digits most significant first, then ';'
            for (int p = 0; p < MaxBytes; p++) begin
               k_v = LenW'(p) - LenW'(pl);
               if (LenW'(p) < LenW'(pl)) begin
                  if (p == 0) begin
                     item.bytes[p] = ChAmp;
                  end else if (p == 1) begin
                     item.bytes[p] = ChHash;
                  end else begin
                     item.bytes[p] = ChX;
                  end
               end else if (k_v < LenW'(nd)) begin
                  d_idx = nd - 3'd1 - k_v[2:0];
                  item.bytes[p] = hex_char(nib[d_idx]);
               end else if (k_v == LenW'(nd)) begin
                  item.bytes[p] = ChSemi;
               end
            end
            item.len = LenW'(pl) + LenW'(nd) + LenW'(1);
         end
         default: begin
            item.bytes[0] = ch;
            item.len      = LenW'(1);
         end
      endcase
   end

endmodule

// ----- sv/xesc_queue.sv -----
// ----------------------------------------------------------------------------
// xesc_queue
// Two-entry queue of expanded byte runs between the front and back parts.
// ----------------------------------------------------------------------------
module xesc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xesc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output xesc_pkg::item_type head_item
);
   import xesc_pkg::*;

   localparam int Depth = 2;

   item_type   mem_ff [Depth];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_push;
   logic       do_pop;

   assign full       = (cnt_ff == 2'(Depth));
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(Depth))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'(Depth)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ----- sv/xesc_back.sv -----
// ----------------------------------------------------------------------------
// xesc_back
// Serializes the head run into the output register, one byte per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module xesc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  xesc_pkg::item_type        head_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [xesc_pkg::ByteW-1:0] rsp_out_byte,
   output logic                      rsp_last_byte
);
   import xesc_pkg::*;

   logic [IdxW-1:0]  idx_ff;
   logic [IdxW-1:0]  idx_in;
   logic             valid_ff;
   logic             valid_in;
   logic [ByteW-1:0] byte_ff;
   logic [ByteW-1:0] byte_in;
   logic             last_ff;
   logic             last_in;
   logic             load;
   logic             is_last;

   assign load    = head_valid && (!valid_ff || rsp_ready);
   assign is_last = (LenW'(idx_ff) == head_item.len - LenW'(1));
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_item.bytes[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? '0 : idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

   // mid-run index implies the run is still at the queue head
   a_idx_has_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> head_valid)
      else $error("byte index without queued run");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (LenW'(idx_ff) < head_item.len))
      else $error("byte index past run length");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff && idx_ff == '0))
      else $error("run popped without last byte");

endmodule

// ----- sv/xml_text_escape_encoder.sv -----
// ----------------------------------------------------------------------------
// xml_text_escape_encoder
// Turns decoded code points into XML-escaped ASCII text, one byte per item.
// ----------------------------------------------------------------------------
//   channel  | ports                          | payload
//   ---------+--------------------------------+------------------------------
//   request  | req_valid / req_ready          | req_code_point[20:0]
//   response | rsp_valid / rsp_ready          | rsp_out_byte[6:0], rsp_last_byte
//   csr      | csr_wr_en                      | csr_wr_data (escape_controls)
//
// The back end emits one byte per cycle while rsp is not stalled; a run holds
// 1 byte for plain characters and 4 to 10 bytes for escapes.
// A request is taken whenever the two-entry run queue has room; a byte of the head
// run is registered into the output register when that register is free, then shown on rsp.
// Reset is synchronous; it empties the queue and sets escape_controls to 1.
// A stall on rsp holds the output register and fills the queue, then req_ready drops.
// ----------------------------------------------------------------------------
module xml_text_escape_encoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [xesc_pkg::CpW-1:0]    req_code_point,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [xesc_pkg::ByteW-1:0]  rsp_out_byte,
   output logic                        rsp_last_byte,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data
);
   import xesc_pkg::*;

   logic     escape_ctl_ff;
   logic     escape_ctl_in;
   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     head_valid;
   logic     pop;

   assign escape_ctl_in = csr_wr_en ? csr_wr_data : escape_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ctl_ff <= 1'b1;
      end else begin
         escape_ctl_ff <= escape_ctl_in;
      end
   end

   assign req_ready = !q_full;

   xesc_front u_front (
      .code_point (req_code_point),
      .escape_ctl (escape_ctl_ff),
      .item       (front_item)
   );

   xesc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   xesc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ----- verif/xesc_escape_checker.sv -----
// ----------------------------------------------------------------------------
// xesc_escape_checker
// Watches the request, response and csr ports of the XML text escape encoder,
// predicts the escaped byte run of every accepted code point and compares each
// response byte, in order, with the oldest byte still owed.
// ----------------------------------------------------------------------------
module xesc_escape_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [xesc_pkg::CpW-1:0]   req_code_point,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [xesc_pkg::ByteW-1:0] rsp_out_byte,
   input  logic                       rsp_last_byte,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   output int                         bytes_owed,
   output int                         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import xesc_pkg::*;

   typedef struct packed {
      logic [ByteW-1:0] ch;
      logic             last;
   } escaped_byte_type;

   escaped_byte_type escaped_bytes_due [$];
   logic             controls_on = 1'b1;
   int               mismatches  = 0;

   // Expand one code point into its escaped text and queue every byte.
   function automatic void predict_escape_run(input logic [CpW-1:0] cp,
                                              input logic controls);
      logic [ByteW-1:0] run [$];
      string            text;
      byte              c;
      logic             bare_control;
      text = "";
      // whitespace controls (tab through carriage return) are never escaped
      bare_control = (cp < 21'h20 || cp == {14'd0, ChDel}) &&
                     !(cp >= 21'h09 && cp <= 21'h0d);
      if (cp == {14'd0, ChLt}) begin
         text = "&lt;";
      end else if (cp == {14'd0, ChApos}) begin
         text = "&apos;";
      end else if (cp == {14'd0, ChQuot}) begin
         text = "&quot;";
      end else if (cp == {14'd0, ChAmp}) begin
         text = "&amp;";
      end else if (cp > 21'h7f) begin
         text = $sformatf("&#x%0h;", cp);
      end else if (controls && bare_control) begin
         text = $sformatf("&#%0d;", cp);
      end else begin
         run.push_back(cp[ByteW-1:0]);
      end
      for (int i = 0; i < text.len(); i++) begin
         c = text.getc(i);
         run.push_back(c[ByteW-1:0]);
      end
      foreach (run[i]) begin
         escaped_bytes_due.push_back('{ch: run[i], last: (i == run.size() - 1)});
      end
   endfunction

   always @(posedge clock) begin
      escaped_byte_type want;
      if (reset) begin
         controls_on = 1'b1;
         escaped_bytes_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (escaped_bytes_due.size() == 0) begin
               $error("unexpected response byte 0x%02h last=%0b", rsp_out_byte,
                      rsp_last_byte);
               mismatches++;
            end else begin
               want = escaped_bytes_due.pop_front();
               if (rsp_out_byte !== want.ch) begin
                  $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                         want.ch, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte mismatch: expected %0b, actual %0b",
                         want.last, rsp_last_byte);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_escape_run(req_code_point, controls_on);
         end
         if (csr_wr_en) begin
            controls_on = csr_wr_data;
         end
      end
      bytes_owed     <= escaped_bytes_due.size();
      mismatch_count <= mismatches;
   end

endmodule

// ----- verif/tb_xml_text_escape_encoder.sv -----
// ----------------------------------------------------------------------------
// tb_xml_text_escape_encoder
// Drives code points in random bursts through the escape encoder under both
// settings of escape_controls, stalls the response side on its own pattern
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_xml_text_escape_encoder;
   timeunit 1ns;
   timeprecision 1ps;
   import xesc_pkg::*;

   localparam int ItemsPerPhase = 49;
   localparam int RandomPhases  = 4;
   localparam int SettleCycles  = 16;
   localparam int HoldOffCycles = 60;

   localparam logic [ByteW-1:0] MarkupChars [4] = '{ChLt, ChApos, ChQuot, ChAmp};

   // boundaries of every class, escaping on (reset value)
   localparam logic [CpW-1:0] EdgePointsOn [20] = '{
      21'h00, 21'h08, 21'h09, 21'h0d, 21'h0e, 21'h1f, 21'h20,
      {14'd0, ChLt}, {14'd0, ChApos}, {14'd0, ChQuot}, {14'd0, ChAmp},
      21'h41, 21'h7e, 21'h7f, 21'h80, 21'hffff, 21'h10000,
      21'h10ffff, 21'h110000, 21'h1fffff
   };
   // controls pass through raw with escaping off
   localparam logic [CpW-1:0] EdgePointsOff [5] = '{
      21'h00, 21'h1b, 21'h7f, 21'h0a, {14'd0, ChAmp}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [CpW-1:0]   req_code_point;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [ByteW-1:0] rsp_out_byte;
   logic             rsp_last_byte;
   logic             csr_wr_en;
   logic             csr_wr_data;
   logic             hold_off_req;
   logic             hold_off_done;
   int               bytes_owed;
   int               mismatch_count;

   xml_text_escape_encoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   xesc_escape_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .bytes_owed     (bytes_owed),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [CpW-1:0] random_code_point();
      logic [CpW-1:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2: cp = CpW'($urandom_range(0, 127));
         3:       cp = {14'd0, MarkupChars[2'($urandom_range(0, 3))]};
         4:       cp = ($urandom_range(0, 7) == 0) ? {14'd0, ChDel} :
                                                     CpW'($urandom_range(0, 31));
         5, 6:    cp = CpW'($urandom_range(128, 21'h10ffff));
         7:       cp = CpW'($urandom_range(128, 16'hffff));
         default: cp = CpW'($urandom & 21'h1fffff);
      endcase
      return cp;
   endfunction

   // Called at a clock edge; returns at the edge where the last item is taken.
   task automatic send_in_bursts(input logic [CpW-1:0] points [$]);
      int idx;
      int burst;
      int gap;
      idx = 0;
      while (idx < points.size()) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && idx < points.size()) begin
            req_valid      <= 1'b1;
            req_code_point <= points[idx];
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (idx < points.size() && gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_until_drained();
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_escape_controls(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: stretches of steady, light and heavy stalling, plus one
   // long hold-off on request so the run queue fills and req_ready drops
   initial begin
      int mode;
      int span;
      rsp_ready     = 1'b0;
      hold_off_done = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
            repeat (span) begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= 1'($urandom_range(0, 1));
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      logic [CpW-1:0] points [$];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_code_point = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      hold_off_req   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset value of escape_controls first
      foreach (EdgePointsOn[i]) points.push_back(EdgePointsOn[i]);
      send_in_bursts(points);
      wait_until_drained();

      write_escape_controls(1'b0);
      points.delete();
      foreach (EdgePointsOff[i]) points.push_back(EdgePointsOff[i]);
      send_in_bursts(points);
      wait_until_drained();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         write_escape_controls(phase % 2 == 0);
         if (phase == 1) begin
            hold_off_req <= 1'b1;
         end
         points.delete();
         repeat (ItemsPerPhase) points.push_back(random_code_point());
         send_in_bursts(points);
         wait_until_drained();
      end

      if (mismatch_count == 0 && bytes_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
